// ===== hw/rtl/rk4s_pkg.sv =====
`timescale 1ns / 1ps

package rk4s_pkg;

    localparam logic [47:0] DIV_OFFSET = 48'hC000_0000_0000;
    localparam logic [47:0] DIV_BIAS   = 48'h4000_0000_0000;

    localparam logic signed [63:0] HALF_SIXTH = 64'sd196608;
    localparam logic signed [63:0] HALF_THIRD = 64'sd98304;
    localparam logic signed [63:0] HALF_HALF  = 64'sd65536;
    localparam logic signed [63:0] HALF_ONE   = 64'sd32768;

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    typedef enum logic [2:0] {
        STG_DONE,
        STG_ONE,
        STG_TWO,
        STG_THREE,
        STG_FOUR
    } stage_t;

    typedef struct packed {
        logic        is_load;
        logic        w_third;
        logic        h_full;
        logic        final_stage;
        logic [5:0]  body;
        logic [1:0]  axis;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  body;
        logic [1:0]  axis;
        logic [31:0] pos;
        logic [31:0] vel;
        logic        done;
        logic        sat;
    } res_t;

    // eight steps of long division by three, remainder in and out
    function automatic logic [9:0] div3_chunk(input logic [1:0] rem, input logic [7:0] bits);
        logic [2:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[1:0], bits[i]};
            if (r >= 3'd3) begin
                q[i] = 1'b1;
                r = r - 3'd3;
            end
        end
        return {r[1:0], q};
    endfunction

    // {clamped flag, value}
    function automatic logic [32:0] sat_add(input logic [31:0] a, input logic [47:0] b);
        logic signed [49:0] s;
        s = $signed({{18{a[31]}}, a}) + $signed({{2{b[47]}}, b});
        if (s > SAT_MAX) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (s < SAT_MIN) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, s[31:0]};
        end
    endfunction

endpackage

// ===== hw/rtl/rk4_stage_integrator_unit.sv =====
`timescale 1ns / 1ps

// rk4 stage integrator, q16.16 per body and axis
// input channel s_*: valid/ready; a load transaction stores the initial state,
// a stage transaction carries velocity and acceleration at the stage point
// result channel m_*: valid/ready; next stage point, or final state with
// m_step_done set after the fourth stage
// cfg_we/cfg_wdata write the time step; write only while the block is idle
// throughput: one transaction per cycle while s_ready is high, limited by the
// slope and accumulator pipeline that reads and writes the state memories once a cycle
// path from input transaction to m_valid: command queue, eleven pipeline
// stages with a divide-by-three unit, output queue
// a 16 entry output queue takes results while m_ready is low; once it is
// reserved full, stage transactions wait in the 4 entry command queue and
// then s_ready drops
// reset: stage counter awaits a load, time step returns to 1.0, queues empty;
// state memories are not cleared

module rk4_stage_integrator_unit #(
    parameter int MAX_BODIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [5:0]  s_body_index,
    input  logic [1:0]  s_axis,
    input  logic [31:0] s_position,
    input  logic [31:0] s_velocity,
    input  logic [31:0] s_acceleration,
    input  logic        s_last_in_pass,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_out_body,
    output logic [1:0]  m_out_axis,
    output logic [31:0] m_out_position,
    output logic [31:0] m_out_velocity,
    output logic        m_step_done,
    output logic        m_saturated
);
    import rk4s_pkg::*;

    logic [30:0] step_size_reg;
    logic        fq_valid;
    logic        fq_ready;
    cmd_t        fq_data;
    logic [$bits(cmd_t)-1:0] bq_bits;
    logic        bq_valid;
    logic        bq_ready;
    cmd_t        bq_data;
    res_t        res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= 31'd65536;
        end else if (cfg_we) begin
            step_size_reg <= cfg_wdata;
        end
    end

    rk4s_front #(
        .MAX_BODIES (MAX_BODIES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_body_index   (s_body_index),
        .s_axis         (s_axis),
        .s_position     (s_position),
        .s_velocity     (s_velocity),
        .s_acceleration (s_acceleration),
        .s_last_in_pass (s_last_in_pass),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_data         (fq_data)
    );

    rk4s_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (4)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_bits)
    );

    assign bq_data = cmd_t'(bq_bits);

    rk4s_back #(
        .MAX_BODIES (MAX_BODIES),
        .OUT_DEPTH  (16)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_size (step_size_reg),
        .cmd_valid (bq_valid),
        .cmd_ready (bq_ready),
        .cmd_data  (bq_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (res)
    );

    assign m_out_body     = res.body;
    assign m_out_axis     = res.axis;
    assign m_out_position = res.pos;
    assign m_out_velocity = res.vel;
    assign m_step_done    = res.done;
    assign m_saturated    = res.sat;

endmodule

// ===== hw/rtl/rk4s_fifo.sv =====
`timescale 1ns / 1ps

module rk4s_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  buf_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != (AW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hw/rtl/rk4s_front.sv =====
`timescale 1ns / 1ps

module rk4s_front #(
    parameter int MAX_BODIES = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_req_type,
    input  logic [5:0]    s_body_index,
    input  logic [1:0]    s_axis,
    input  logic [31:0]   s_position,
    input  logic [31:0]   s_velocity,
    input  logic [31:0]   s_acceleration,
    input  logic          s_last_in_pass,
    output logic          q_valid,
    input  logic          q_ready,
    output rk4s_pkg::cmd_t q_data
);
    import rk4s_pkg::*;

    stage_t stage_reg;
    stage_t stage_next;
    logic   accept;
    logic   in_range;

    assign s_ready  = q_ready;
    assign accept   = s_valid && q_ready;
    assign in_range = 32'(s_body_index) < MAX_BODIES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STG_DONE;
        end else begin
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        stage_next               = stage_reg;
        q_valid                  = 1'b0;
        q_data.meta.is_load      = !s_req_type;
        q_data.meta.w_third      = (stage_reg == STG_TWO) || (stage_reg == STG_THREE);
        q_data.meta.h_full       = stage_reg == STG_THREE;
        q_data.meta.final_stage  = stage_reg == STG_FOUR;
        q_data.meta.body         = s_body_index;
        q_data.meta.axis         = s_axis;
        q_data.pos               = s_position;
        q_data.vel               = s_velocity;
        q_data.acc               = s_acceleration;
        if (s_valid && in_range) begin
            if (!s_req_type) begin
                q_valid = 1'b1;
                if (accept) begin
                    stage_next = STG_ONE;
                end
            end else if (stage_reg != STG_DONE) begin
                q_valid = 1'b1;
                if (accept && s_last_in_pass) begin
                    unique case (stage_reg)
                        STG_ONE:   stage_next = STG_TWO;
                        STG_TWO:   stage_next = STG_THREE;
                        STG_THREE: stage_next = STG_FOUR;
                        default:   stage_next = STG_DONE;
                    endcase
                end
            end
        end
    end

endmodule

// ===== hw/rtl/rk4s_back.sv =====
`timescale 1ns / 1ps

module rk4s_back #(
    parameter int MAX_BODIES = 64,
    parameter int OUT_DEPTH  = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [30:0]    step_size,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  rk4s_pkg::cmd_t cmd_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rk4s_pkg::res_t m_data
);
    import rk4s_pkg::*;

    localparam int ENTRIES = MAX_BODIES * 4;
    localparam int IW      = $clog2(ENTRIES);
    localparam int RW      = $clog2(OUT_DEPTH + 1);
    localparam int NST     = 11;

    function automatic logic [IW-1:0] idx_of(input meta_t m);
        return IW'({m.body, m.axis});
    endfunction

    logic [NST-1:0]     vld_reg;
    meta_t              meta_reg [NST];
    logic [31:0]        pos_reg [9];
    logic [31:0]        vel_reg [9];
    logic signed [31:0] acc0_reg;
    logic signed [63:0] pa_reg;
    logic signed [63:0] pv_reg;
    logic [47:0]        da_reg [7];
    logic [47:0]        dv_reg [7];
    logic [1:0]         ra_reg [6];
    logic [1:0]         rb_reg [6];
    logic [47:0]        ih_reg [2:8];
    logic [RW-1:0]      reserved_reg;

    logic [31:0] mem_ip [ENTRIES];
    logic [31:0] mem_iv [ENTRIES];
    logic [31:0] mem_sp [ENTRIES];
    logic [31:0] mem_sv [ENTRIES];
    logic [31:0] rd_ip_reg;
    logic [31:0] rd_iv_reg;
    logic [31:0] rd_sp_reg;
    logic [31:0] rd_sv_reg;

    logic [31:0]        sp9_reg;
    logic [31:0]        sv9_reg;
    logic [31:0]        ip9_reg;
    logic [31:0]        iv9_reg;
    logic [31:0]        rv9_reg;
    logic               sat9_reg;
    logic [31:0]        sp10_reg;
    logic [31:0]        sv10_reg;
    logic [31:0]        ip10_reg;
    logic [31:0]        rv10_reg;
    logic               sat10_reg;
    logic signed [63:0] pr10_reg;

    logic               pop;
    logic               push;
    logic               of_in_ready;
    logic               out_take;
    meta_t              cmd_meta;
    logic signed [31:0] dts;

    logic signed [63:0] na;
    logic signed [63:0] nv;
    logic signed [63:0] nh;
    logic signed [63:0] ma;
    logic signed [63:0] mv;
    logic signed [63:0] mh;

    logic [47:0] da_next [6];
    logic [47:0] dv_next [6];
    logic [1:0]  ra_next [6];
    logic [1:0]  rb_next [6];

    logic        fw_hit;
    logic        fw_init;
    logic [31:0] cur_ip;
    logic [31:0] cur_iv;
    logic [31:0] cur_sp;
    logic [31:0] cur_sv;
    logic [32:0] sv_sum;
    logic [32:0] sp_sum;
    logic [32:0] rv_sum;
    logic [31:0] wr_ip;
    logic [31:0] wr_iv;
    logic [31:0] wr_sp;
    logic [31:0] wr_sv;
    logic        sat8;

    logic signed [63:0] nr;
    logic signed [63:0] mr;
    logic [32:0]        rp_sum;
    res_t               res;

    assign cmd_meta  = cmd_data.meta;
    assign cmd_ready = cmd_meta.is_load || (reserved_reg < RW'(OUT_DEPTH));
    assign pop       = cmd_valid && cmd_ready;
    assign dts       = $signed({1'b0, step_size});
    assign out_take  = m_valid && m_ready;

    // slope rounding and scaling ahead of the divide-by-three pipeline
    always_comb begin
        na = pa_reg + (meta_reg[1].w_third ? HALF_THIRD : HALF_SIXTH);
        nv = pv_reg + (meta_reg[1].w_third ? HALF_THIRD : HALF_SIXTH);
        nh = pa_reg + (meta_reg[1].h_full ? HALF_ONE : HALF_HALF);
        ma = meta_reg[1].w_third ? (na >>> 16) : (na >>> 17);
        mv = meta_reg[1].w_third ? (nv >>> 16) : (nv >>> 17);
        mh = meta_reg[1].h_full ? (nh >>> 16) : (nh >>> 17);
    end

    always_comb begin
        logic [9:0]  ca;
        logic [9:0]  cb;
        logic [47:0] ta;
        logic [47:0] tb;
        for (int s = 0; s < 6; s++) begin
            ta = da_reg[s];
            tb = dv_reg[s];
            ca = div3_chunk(ra_reg[s], ta[47-8*s -: 8]);
            cb = div3_chunk(rb_reg[s], tb[47-8*s -: 8]);
            ta[47-8*s -: 8] = ca[7:0];
            tb[47-8*s -: 8] = cb[7:0];
            da_next[s] = ta;
            dv_next[s] = tb;
            ra_next[s] = ca[9:8];
            rb_next[s] = cb[9:8];
        end
    end

    // accumulate and first half of the next stage point
    always_comb begin
        fw_hit  = vld_reg[9] && (idx_of(meta_reg[9]) == idx_of(meta_reg[8]));
        fw_init = fw_hit && meta_reg[9].is_load;
        cur_ip  = fw_init ? ip9_reg : rd_ip_reg;
        cur_iv  = fw_init ? iv9_reg : rd_iv_reg;
        cur_sp  = fw_hit ? sp9_reg : rd_sp_reg;
        cur_sv  = fw_hit ? sv9_reg : rd_sv_reg;
        sv_sum  = sat_add(cur_sv, da_reg[6] - DIV_BIAS);
        sp_sum  = sat_add(cur_sp, dv_reg[6] - DIV_BIAS);
        rv_sum  = sat_add(cur_iv, ih_reg[8]);
        sat8    = sv_sum[32] || sp_sum[32] || (!meta_reg[8].final_stage && rv_sum[32]);
        if (meta_reg[8].is_load) begin
            wr_ip = pos_reg[8];
            wr_iv = vel_reg[8];
            wr_sp = pos_reg[8];
            wr_sv = vel_reg[8];
        end else begin
            wr_ip = cur_ip;
            wr_iv = cur_iv;
            wr_sp = sp_sum[31:0];
            wr_sv = sv_sum[31:0];
        end
    end

    // position of the next stage point and result assembly
    always_comb begin
        nr       = pr10_reg + (meta_reg[10].h_full ? HALF_ONE : HALF_HALF);
        mr       = meta_reg[10].h_full ? (nr >>> 16) : (nr >>> 17);
        rp_sum   = sat_add(ip10_reg, mr[47:0]);
        res.body = meta_reg[10].body;
        res.axis = meta_reg[10].axis;
        res.done = meta_reg[10].final_stage;
        if (meta_reg[10].final_stage) begin
            res.pos = sp10_reg;
            res.vel = sv10_reg;
            res.sat = sat10_reg;
        end else begin
            res.pos = rp_sum[31:0];
            res.vel = rv10_reg;
            res.sat = sat10_reg || rp_sum[32];
        end
        push = vld_reg[10] && !meta_reg[10].is_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            reserved_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NST-2:0], pop};
            if ((pop && !cmd_meta.is_load) && !out_take) begin
                reserved_reg <= reserved_reg + 1'b1;
            end else if (!(pop && !cmd_meta.is_load) && out_take) begin
                reserved_reg <= reserved_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        meta_reg[0] <= cmd_meta;
        pos_reg[0]  <= cmd_data.pos;
        vel_reg[0]  <= cmd_data.vel;
        acc0_reg    <= $signed(cmd_data.acc);
        for (int s = 1; s < NST; s++) begin
            meta_reg[s] <= meta_reg[s-1];
        end
        for (int s = 1; s < 9; s++) begin
            pos_reg[s] <= pos_reg[s-1];
            vel_reg[s] <= vel_reg[s-1];
        end

        pa_reg <= acc0_reg * dts;
        pv_reg <= $signed(vel_reg[0]) * dts;

        da_reg[0] <= ma[47:0] + DIV_OFFSET;
        dv_reg[0] <= mv[47:0] + DIV_OFFSET;
        ra_reg[0] <= '0;
        rb_reg[0] <= '0;
        ih_reg[2] <= mh[47:0];
        for (int s = 0; s < 6; s++) begin
            da_reg[s+1] <= da_next[s];
            dv_reg[s+1] <= dv_next[s];
        end
        for (int s = 0; s < 5; s++) begin
            ra_reg[s+1] <= ra_next[s];
            rb_reg[s+1] <= rb_next[s];
        end
        for (int s = 3; s < 9; s++) begin
            ih_reg[s] <= ih_reg[s-1];
        end

        sp9_reg  <= wr_sp;
        sv9_reg  <= wr_sv;
        ip9_reg  <= wr_ip;
        iv9_reg  <= wr_iv;
        rv9_reg  <= rv_sum[31:0];
        sat9_reg <= sat8;

        sp10_reg  <= sp9_reg;
        sv10_reg  <= sv9_reg;
        ip10_reg  <= ip9_reg;
        rv10_reg  <= rv9_reg;
        sat10_reg <= sat9_reg;
        pr10_reg  <= $signed(rv9_reg) * dts;
    end

    always_ff @(posedge aclk) begin
        rd_ip_reg <= mem_ip[idx_of(meta_reg[7])];
        rd_iv_reg <= mem_iv[idx_of(meta_reg[7])];
        rd_sp_reg <= mem_sp[idx_of(meta_reg[7])];
        rd_sv_reg <= mem_sv[idx_of(meta_reg[7])];
        if (vld_reg[8]) begin
            mem_sp[idx_of(meta_reg[8])] <= wr_sp;
            mem_sv[idx_of(meta_reg[8])] <= wr_sv;
            if (meta_reg[8].is_load) begin
                mem_ip[idx_of(meta_reg[8])] <= wr_ip;
                mem_iv[idx_of(meta_reg[8])] <= wr_iv;
            end
        end
    end

    rk4s_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (of_in_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg <= RW'(OUT_DEPTH))
        else $error("result credit count overrun");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> of_in_ready)
        else $error("result pushed into full output queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_take |-> (reserved_reg != '0))
        else $error("result transaction without a reserved slot");

endmodule
